// File: rtl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int ROWS    = 25;
  localparam int COLUMNS = 80;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int AW      = $clog2(CELLS);

  // Field widths
  localparam int RW     = 5;
  localparam int CW     = 7;
  localparam int PW     = 11;
  localparam int CELL_W = 16;
  localparam int COLOR_W = 4;
  localparam int CFG_IW = 1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,    // clearing pass after reset
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  localparam logic [CFG_IW-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_BG = 1'b1;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

endpackage

// File: rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/text_console_writer.sv
// Text console writer: a ROWS x COLUMNS (25 x 80) screen of 16-bit cells
// (character in the low byte, attribute {background, foreground} in the high
// byte) held in one simple dual-port RAM, plus a cursor. Each input item is
// one operation (put character, set cursor, clear screen, read cell) and
// gives exactly one result item with the cursor after the operation and,
// for a read, the cell content. Items are processed one at a time; in_stall
// is low only while the block is idle, but an item is taken while the
// previous result still sits in the output register.
// From acceptance, a put, set cursor or control character passes the
// execute and done states before out_valid; a read also passes a read state
// for the RAM read latency. The next item is taken only once the done state
// has handed its result to the output register and the block is idle again.
// A newline or a wrap on the last row scrolls: one copy pass over the first
// (ROWS-1)*COLUMNS cells at one cell per cycle through the single RAM port
// pair plus a read lead-in, then a pass blanking the COLUMNS cells of the
// bottom row. Clear screen writes every cell once. After reset the block
// runs a clearing pass over all ROWS*COLUMNS (2000) cells that fills the
// screen with grey blanks (0x0720) and accepts no item until it is done;
// color register writes are taken at any time, including during that pass.
// Configuration must only be written while no item is in flight.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [COLOR_W-1:0] cfg_wdata,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [7:0]         in_char_code,
  input  logic [RW-1:0]      in_target_row,
  input  logic [CW-1:0]      in_target_col,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [RW-1:0]      out_cursor_row,
  output logic [CW-1:0]      out_cursor_col,
  output logic [PW-1:0]      out_cursor_position,
  output logic [CELL_W-1:0]  out_cell_data
);

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END   = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

  // Control state
  state_t              state_r, state_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [COLOR_W-1:0]  fg_r, bg_r;
  logic                out_valid_r, out_valid_nxt;

  // Item and result payload
  op_t                 op_r, op_nxt;
  logic [7:0]          ch_r, ch_nxt;
  logic [RW-1:0]       trow_r, trow_nxt;
  logic [CW-1:0]       tcol_r, tcol_nxt;
  logic [CELL_W-1:0]   data_r, data_nxt;
  logic [RW-1:0]       out_row_r, out_row_nxt;
  logic [CW-1:0]       out_col_r, out_col_nxt;
  logic [PW-1:0]       out_pos_r, out_pos_nxt;
  logic [CELL_W-1:0]   out_data_r, out_data_nxt;

  // RAM port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [CELL_W-1:0]   ram_wdata, ram_rdata;

  logic [CELL_W-1:0]   blank_cell;
  logic [AW-1:0]       cur_addr, bs_addr, tgt_addr;
  logic [CW-1:0]       col_dec;
  logic                in_take, out_free, is_ctrl, wraps, scroll_req;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign blank_cell = {bg_r, fg_r, CH_BLANK};
  assign col_dec    = col_r - CW'(1);
  assign cur_addr   = AW'(row_r) * ROW_STRIDE + AW'(col_r);
  assign bs_addr    = AW'(row_r) * ROW_STRIDE + AW'(col_dec);
  assign tgt_addr   = AW'(trow_r) * ROW_STRIDE + AW'(tcol_r);

  // Newline, return and backspace are the only bytes not stored as glyphs
  assign is_ctrl    = (ch_r == CH_NEWLINE) || (ch_r == CH_RETURN) ||
                      (ch_r == CH_BACKSPACE);
  assign wraps      = (ch_r == CH_NEWLINE) || (!is_ctrl && col_r == LAST_COL);
  assign scroll_req = wraps && (row_r == LAST_ROW);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:   if (ptr_r == LAST_CELL) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        unique case (op_r)
          OP_PUT:   state_nxt = scroll_req ? ST_SCROLL : ST_DONE;
          OP_SET:   state_nxt = ST_DONE;
          OP_CLEAR: state_nxt = ST_FILL;
          OP_READ:  state_nxt = ST_READ;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_READ:   state_nxt = ST_DONE;
      ST_SCROLL: if (ptr_r == COPY_END) state_nxt = ST_FILL;
      ST_FILL:   if (ptr_r == LAST_CELL) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM control and result register
  always_comb begin
    ptr_nxt      = ptr_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    op_nxt       = op_r;
    ch_nxt       = ch_r;
    trow_nxt     = trow_r;
    tcol_nxt     = tcol_r;
    data_nxt     = data_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_pos_nxt  = out_pos_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = blank_cell;
    ram_raddr = tgt_addr;

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_CELL;
        ptr_nxt   = ptr_r + AW'(1);
      end

      ST_IDLE: begin
        if (in_take) begin
          op_nxt   = op_t'(in_operation);
          ch_nxt   = in_char_code;
          // out-of-range targets saturate to the last row / column
          trow_nxt = (int'(in_target_row) >= ROWS) ? LAST_ROW : in_target_row;
          tcol_nxt = (int'(in_target_col) >= COLUMNS) ? LAST_COL : in_target_col;
        end
      end

      ST_EXEC: begin
        data_nxt = '0;
        ptr_nxt  = '0;
        unique case (op_r)
          OP_PUT: begin
            priority if (ch_r == CH_RETURN) begin
              col_nxt = '0;
            end else if (ch_r == CH_BACKSPACE) begin
              if (col_r != '0) begin
                col_nxt   = col_dec;
                ram_we    = 1'b1;
                ram_waddr = bs_addr;
              end
            end else begin
              if (ch_r != CH_NEWLINE) begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {bg_r, fg_r, ch_r};
                col_nxt   = col_r + CW'(1);
              end
              if (wraps) begin
                col_nxt = '0;
                // on the last row the row stays and the screen scrolls
                if (row_r != LAST_ROW) row_nxt = row_r + RW'(1);
              end
            end
          end
          OP_SET: begin
            row_nxt = trow_r;
            col_nxt = tcol_r;
          end
          OP_CLEAR: begin
            row_nxt = '0;
            col_nxt = '0;
          end
          OP_READ: begin
            ram_raddr = tgt_addr;
          end
          default: ;
        endcase
      end

      ST_READ: begin
        data_nxt = ram_rdata;
      end

      // Copy pass: read cell ptr+COLUMNS and write it in the following cycle, once ptr has advanced, to ptr-1.
      ST_SCROLL: begin
        ram_raddr = (ptr_r == COPY_END) ? '0 : ptr_r + ROW_STRIDE;
        ram_we    = (ptr_r != '0);
        ram_waddr = ptr_r - AW'(1);
        ram_wdata = ram_rdata;
        // hold at the end so the bottom-row fill starts at its first cell
        if (ptr_r != COPY_END) ptr_nxt = ptr_r + AW'(1);
      end

      ST_FILL: begin
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + AW'(1);
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          out_pos_nxt   = PW'(int'(row_r) * COLUMNS + int'(col_r));
          out_data_nxt  = data_r;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ptr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Color registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FG:  fg_r <= cfg_wdata;
        CFG_BG:  bg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ch_r       <= ch_nxt;
    trow_r     <= trow_nxt;
    tcol_r     <= tcol_nxt;
    data_r     <= data_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_pos_r  <= out_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_cursor_row      = out_row_r;
  assign out_cursor_col      = out_col_r;
  assign out_cursor_position = out_pos_r;
  assign out_cell_data       = out_data_r;

  // Checks
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(row_r) < ROWS) && (int'(col_r) < COLUMNS))
    else $error("cursor out of screen");

  a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted item not executed");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL) |-> (row_r == LAST_ROW))
    else $error("scroll while not on last row");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result without finished item");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (int'(ram_waddr) < CELLS))
    else $error("screen write out of range");

endmodule

// File: test/text_console_writer_tb.sv
module text_console_writer_tb;
  import tcw_pkg::*;

  // One result item as the block reports it after an operation.
  typedef struct packed {
    logic [RW-1:0]     row;
    logic [CW-1:0]     col;
    logic [PW-1:0]     pos;
    logic [CELL_W-1:0] data;
  } cursor_report_t;

  // Scoreboard: keeps a shadow screen, cursor and color pair, works out the
  // report each accepted item should produce and checks reports in order.
  class console_scoreboard;
    logic [CELL_W-1:0]  cells [CELLS];
    int                 cur_row;
    int                 cur_col;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    cursor_report_t     pending_reports[$];
    int                 errors;

    function new();
      foreach (cells[i]) cells[i] = RESET_CELL;
      cur_row = 0;
      cur_col = 0;
      fg      = FG_RESET;
      bg      = BG_RESET;
      errors  = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void set_colors(logic [COLOR_W-1:0] f, logic [COLOR_W-1:0] b);
      fg = f;
      bg = b;
    endfunction

    function logic [CELL_W-1:0] paint(logic [7:0] ch);
      return {bg, fg, ch};
    endfunction

    // Newline / wrap: past the bottom row the screen moves up one row.
    function void line_feed();
      int i;
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
        for (i = 0; i < (ROWS - 1) * COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++) cells[i] = paint(CH_BLANK);
        cur_row = ROWS - 1;
      end
    endfunction

    function void note_item(op_t op, logic [7:0] ch, logic [RW-1:0] r, logic [CW-1:0] c);
      int             tr;
      int             tc;
      cursor_report_t rep;
      tr = (r >= ROWS) ? ROWS - 1 : r;
      tc = (c >= COLUMNS) ? COLUMNS - 1 : c;
      rep.data = '0;
      case (op)
        OP_PUT: begin
          if (ch == CH_NEWLINE) begin
            line_feed();
          end else if (ch == CH_RETURN) begin
            cur_col = 0;
          end else if (ch == CH_BACKSPACE) begin
            if (cur_col > 0) begin
              cur_col--;
              cells[cur_row * COLUMNS + cur_col] = paint(CH_BLANK);
            end
          end else begin
            cells[cur_row * COLUMNS + cur_col] = paint(ch);
            cur_col++;
            if (cur_col >= COLUMNS) line_feed();
          end
        end
        OP_SET: begin
          cur_row = tr;
          cur_col = tc;
        end
        OP_CLEAR: begin
          foreach (cells[i]) cells[i] = paint(CH_BLANK);
          cur_row = 0;
          cur_col = 0;
        end
        default: begin
          rep.data = cells[tr * COLUMNS + tc];
        end
      endcase
      rep.row = RW'(cur_row);
      rep.col = CW'(cur_col);
      rep.pos = PW'(cur_row * COLUMNS + cur_col);
      pending_reports.push_back(rep);
    endfunction

    task check_report(cursor_report_t got);
      cursor_report_t want;
      if (pending_reports.size() == 0) begin
        report("result item with no operation outstanding");
        return;
      end
      want = pending_reports.pop_front();
      if (got.row !== want.row)
        report($sformatf("cursor_row %0d, expected %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("cursor_col %0d, expected %0d", got.col, want.col));
      if (got.pos !== want.pos)
        report($sformatf("cursor_position %0d, expected %0d", got.pos, want.pos));
      if (got.data !== want.data)
        report($sformatf("cell_data %h, expected %h", got.data, want.data));
    endtask
  endclass

  // ------------------------------------------------------------------------
  // Clock, reset and block signals. Every driven signal starts at a known value.
  // ------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;

  logic               cfg_we = 1'b0;
  logic [CFG_IW-1:0]  cfg_index = CFG_FG;
  logic [COLOR_W-1:0] cfg_wdata = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  op_t                in_operation = OP_PUT;
  logic [7:0]         in_char_code = '0;
  logic [RW-1:0]      in_target_row = '0;
  logic [CW-1:0]      in_target_col = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RW-1:0]      out_cursor_row;
  logic [CW-1:0]      out_cursor_col;
  logic [PW-1:0]      out_cursor_position;
  logic [CELL_W-1:0]  out_cell_data;

  // Percent of cycles either side idles; zero gives a stretch at full rate.
  int                 idle_pct = 23;

  console_scoreboard  sb = new();

  always #4 clk = ~clk;

  text_console_writer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_char_code        (in_char_code),
    .in_target_row       (in_target_row),
    .in_target_col       (in_target_col),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_col      (out_cursor_col),
    .out_cursor_position (out_cursor_position),
    .out_cell_data       (out_cell_data)
  );

  // ------------------------------------------------------------------------
  // Monitor: samples both handshakes at the edge (all drivers are NBA, so
  // these are the values the block saw) and also drives the random result
  // stall, which never looks at out_valid.
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_item(in_operation, in_char_code, in_target_row, in_target_col);
    if (rst_n && out_valid && !out_stall)
      sb.check_report(cursor_report_t'{out_cursor_row, out_cursor_col,
                                       out_cursor_position, out_cell_data});
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------

  // Present one item, with random idle cycles before it, and hold it until
  // the block takes it. Returns right after the accepting edge so the next
  // item can follow back to back.
  task automatic send_item(input op_t op, input logic [7:0] ch,
                           input logic [RW-1:0] r, input logic [CW-1:0] c);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_char_code  <= ch;
    in_target_row <= r;
    in_target_col <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random item. Rows lean toward the bottom so newlines and line wraps
  // scroll now and then; clear is rare since it walks the whole screen.
  // Rows and columns also go past the screen to hit the saturation paths.
  task automatic send_random();
    op_t           op;
    logic [7:0]    ch;
    logic [RW-1:0] r;
    logic [CW-1:0] c;
    int            roll;
    roll = $urandom_range(99);
    if (roll < 58)      op = OP_PUT;
    else if (roll < 73) op = OP_SET;
    else if (roll < 74) op = OP_CLEAR;
    else                op = OP_READ;
    roll = $urandom_range(99);
    if (roll < 5)       ch = CH_NEWLINE;
    else if (roll < 10) ch = CH_RETURN;
    else if (roll < 18) ch = CH_BACKSPACE;
    else                ch = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 25)      r = RW'(ROWS - 1);
    else if (roll < 30) r = RW'($urandom_range(31, ROWS));
    else                r = RW'($urandom_range(ROWS - 1));
    roll = $urandom_range(99);
    if (roll < 15)      c = CW'(COLUMNS - 1);
    else if (roll < 25) c = CW'($urandom_range(127, COLUMNS));
    else                c = CW'($urandom_range(COLUMNS - 1));
    send_item(op, ch, r, c);
  endtask

  // Both color registers, one per edge, while nothing is in flight.
  task automatic set_colors(input logic [COLOR_W-1:0] f, input logic [COLOR_W-1:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FG;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_index <= CFG_BG;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_colors(f, b);
  endtask

  // Wait for every outstanding report. The bound covers a scroll plus
  // plenty of output stall; anything still missing after it is a failure.
  task automatic drain();
    int waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending_reports.size() != 0 && waited < 20000);
    if (sb.pending_reports.size() != 0)
      sb.report($sformatf("%0d result items never arrived", sb.pending_reports.size()));
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    logic [COLOR_W-1:0] plan_fg [5];
    logic [COLOR_W-1:0] plan_bg [5];
    logic [COLOR_W-1:0] f;
    logic [COLOR_W-1:0] b;
    int                 phase;
    int                 n;

    // color settings per phase: defaults, both extremes, mixed extremes,
    // then random pairs
    plan_fg = '{4'd7, 4'd0, 4'd15, 4'd0, 4'd15};
    plan_bg = '{4'd0, 4'd0, 4'd15, 4'd15, 4'd0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < 8; phase++) begin
      if (phase < 5) begin
        f = plan_fg[phase];
        b = plan_bg[phase];
      end else begin
        f = COLOR_W'($urandom_range(15));
        b = COLOR_W'($urandom_range(15));
      end
      // the block may still be in its power-up clearing pass here; color
      // writes are taken then too, items simply wait on in_stall
      set_colors(f, b);

      // phase 3 runs with no idling on either side
      idle_pct = (phase == 3) ? 0 : 23;

      if (phase == 0) begin
        send_item(OP_READ, 8'h00, 5'd0, 7'd0);           // untouched cell
        send_item(OP_PUT, 8'h41, 5'd0, 7'd0);
        send_item(OP_PUT, 8'h00, 5'd31, 7'd127);         // low extreme byte
        send_item(OP_PUT, 8'hFF, 5'd0, 7'd0);            // high extreme byte
        send_item(OP_PUT, 8'h80, 5'd0, 7'd0);
        send_item(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0);     // blank previous cell
        send_item(OP_READ, 8'h00, 5'd0, 7'd3);
        send_item(OP_PUT, CH_RETURN, 5'd0, 7'd0);
        send_item(OP_PUT, CH_BACKSPACE, 5'd0, 7'd0);     // at column 0: no-op
        send_item(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
        send_item(OP_SET, 8'h00, 5'd31, 7'd127);         // saturates to corner
        send_item(OP_READ, 8'h00, 5'd31, 7'd127);        // saturated read
        send_item(OP_PUT, 8'h7E, 5'd0, 7'd0);            // wrap on last row
        send_item(OP_READ, 8'h00, 5'd23, 7'd79);         // moved up one row
        send_item(OP_READ, 8'h00, 5'd0, 7'd0);
        send_item(OP_SET, 8'h00, 5'd24, 7'd10);
        send_item(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);       // newline scroll
        send_item(OP_READ, 8'h00, 5'd24, 7'd10);         // fresh blank row
        send_item(OP_SET, 8'h00, 5'd5, 7'd79);
        send_item(OP_PUT, 8'h55, 5'd0, 7'd0);            // ordinary wrap
        send_item(OP_SET, 8'h00, 5'd25, 7'd80);          // just past the edge
        send_item(OP_CLEAR, 8'h00, 5'd0, 7'd0);
        send_item(OP_READ, 8'h00, 5'd12, 7'd40);
        send_item(OP_PUT, 8'h09, 5'd0, 7'd0);            // control byte stored
        send_item(OP_READ, 8'h00, 5'd0, 7'd0);
      end

      for (n = 0; n < 200; n++) send_random();
      in_valid <= 1'b0;
      drain();
    end

    // let any stray extra result show up before judging
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (every item scrolling).
  initial begin
    #100_000_000;
    $display("text_console_writer verification failed");
    $finish;
  end

endmodule
